// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks shared by the detector modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: sv/mbpd_pkg.sv
// ----------------------------------------------------------------------------
// mbpd_pkg
// shared types and constants of the morse beam pattern detector
// ----------------------------------------------------------------------------
package mbpd_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_THRESHOLD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_DOT_TIME   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_DASH_TIME  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_IDLE_TMO   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_TARGET_SYM = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_TARGET_LEN = 3'd5;

    // register reset values
    localparam logic [11:0] RST_THRESHOLD  = 12'd2048;
    localparam logic [15:0] RST_DOT_TIME   = 16'd200;
    localparam logic [15:0] RST_DASH_TIME  = 16'd600;
    localparam logic [31:0] RST_IDLE_TMO   = 32'd2000;
    localparam logic [31:0] RST_TARGET_SYM = 32'd0;
    localparam logic [5:0]  RST_TARGET_LEN = 6'd0;

    // shortest break that counts as a dot, exclusive
    localparam logic [31:0] MIN_BREAK_MS = 32'd50;

    // longest target sequence that can ever match
    localparam logic [5:0] TARGET_MAX_LEN = 6'd32;

    typedef struct packed {
        logic [11:0] light_threshold;
        logic [15:0] dot_time_ms;
        logic [15:0] dash_time_ms;
        logic [31:0] idle_timeout_ms;
        logic [31:0] target_symbols;
        logic [5:0]  target_length;
    } t_cfg;

    typedef struct packed {
        logic       matched;
        logic       beam_cut;
        logic [5:0] symbol_count;
    } t_result;

endpackage

// File: sv/mbpd_cfg.sv
// ----------------------------------------------------------------------------
// mbpd_cfg
// configuration register file, written one register per beat
// ----------------------------------------------------------------------------
module mbpd_cfg
    import mbpd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  logic [CFG_INDEX_W-1:0] i_index,
    input  logic [CFG_DATA_W-1:0]  i_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // decode the write, unknown indexes leave everything alone
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                CFG_IDX_THRESHOLD:  n_cfg.light_threshold = i_data[11:0];
                CFG_IDX_DOT_TIME:   n_cfg.dot_time_ms     = i_data[15:0];
                CFG_IDX_DASH_TIME:  n_cfg.dash_time_ms    = i_data[15:0];
                CFG_IDX_IDLE_TMO:   n_cfg.idle_timeout_ms = i_data;
                CFG_IDX_TARGET_SYM: n_cfg.target_symbols  = i_data;
                CFG_IDX_TARGET_LEN: n_cfg.target_length   = i_data[5:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_threshold <= RST_THRESHOLD;
            r_cfg.dot_time_ms     <= RST_DOT_TIME;
            r_cfg.dash_time_ms    <= RST_DASH_TIME;
            r_cfg.idle_timeout_ms <= RST_IDLE_TMO;
            r_cfg.target_symbols  <= RST_TARGET_SYM;
            r_cfg.target_length   <= RST_TARGET_LEN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/mbpd_core.sv
// ----------------------------------------------------------------------------
// mbpd_core
// break timing, dot/dash classification, symbol store and target match
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbpd_core
    import mbpd_pkg::*;
#(
    parameter int MAX_SYMBOLS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [11:0] i_sample,
    input  logic [31:0] i_time,
    input  t_cfg        i_cfg,
    output t_result     o_result
);

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

    // timing phase and symbol store
    logic                   r_timing;
    logic [31:0]            r_break_start;
    logic [31:0]            r_last_symbol;
    logic [MAX_SYMBOLS-1:0] r_store;
    logic [CNT_W-1:0]       r_count;

    logic                   n_timing;
    logic [31:0]            n_break_start;
    logic [31:0]            n_last_symbol;
    logic [MAX_SYMBOLS-1:0] n_store;
    logic [CNT_W-1:0]       n_count;

    logic                   w_broken;
    logic [31:0]            w_brk_len;
    logic [31:0]            w_idle_len;
    logic [16:0]            w_dot_hi;
    logic [15:0]            w_dash_lo;
    logic [16:0]            w_dash_hi;
    logic                   w_is_dot;
    logic                   w_is_dash;
    logic                   w_has_room;
    logic [MAX_SYMBOLS-1:0] w_app_store;
    logic [CNT_W-1:0]       w_app_count;
    logic                   w_app_timing;
    logic [31:0]            w_app_last;
    logic [31:0]            w_mask;
    logic                   w_match;

    // beam state and elapsed times, both wrap modulo 2^32
    assign w_broken   = i_sample < i_cfg.light_threshold;
    assign w_brk_len  = i_time - r_break_start;
    assign w_idle_len = i_time - r_last_symbol;

    // class windows: dot in (50, 1.5 dot), dash in (dash - dash/2, dash + dash/2), dot wins an overlap
    assign w_dot_hi  = 17'(i_cfg.dot_time_ms) + 17'(i_cfg.dot_time_ms >> 1);
    assign w_dash_lo = i_cfg.dash_time_ms - (i_cfg.dash_time_ms >> 1);
    assign w_dash_hi = 17'(i_cfg.dash_time_ms) + 17'(i_cfg.dash_time_ms >> 1);
    assign w_is_dot  = (w_brk_len > MIN_BREAK_MS) && (w_brk_len < 32'(w_dot_hi));
    assign w_is_dash = !w_is_dot && (w_brk_len > 32'(w_dash_lo))
                       && (w_brk_len < 32'(w_dash_hi));

    assign w_has_room = r_count < CNT_W'(MAX_SYMBOLS);

    // phase update, idle timeout clear and symbol append
    always_comb begin
        w_app_timing = r_timing;
        w_app_store  = r_store;
        w_app_count  = r_count;
        w_app_last   = r_last_symbol;
        n_break_start = r_break_start;
        if (!r_timing) begin
            if (w_broken) begin
                n_break_start = i_time;
                w_app_timing  = 1'b1;
            end else if ((r_count != '0) && (w_idle_len > i_cfg.idle_timeout_ms)) begin
                w_app_store = '0;
                w_app_count = '0;
            end
        end else if (!w_broken) begin
            if ((w_is_dot || w_is_dash) && w_has_room) begin
                if (w_is_dash) begin
                    w_app_store = r_store | (MAX_SYMBOLS'(1) << r_count);
                end
                w_app_count = r_count + 1'b1;
                w_app_last  = i_time;
            end
            w_app_timing = 1'b0;
        end
    end

    // compare the store with the target over the target length
    assign w_mask  = 32'((33'd1 << i_cfg.target_length) - 33'd1);
    assign w_match = (i_cfg.target_length <= TARGET_MAX_LEN)
                     && (7'(w_app_count) == 7'(i_cfg.target_length))
                     && (((32'(w_app_store) ^ i_cfg.target_symbols) & w_mask) == '0);

    // a match clears store and phase, last symbol time is kept
    always_comb begin
        n_timing      = w_app_timing;
        n_store       = w_app_store;
        n_count       = w_app_count;
        n_last_symbol = w_app_last;
        if (w_match) begin
            n_timing = 1'b0;
            n_store  = '0;
            n_count  = '0;
        end
    end

    // state registers advance once per processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing      <= 1'b0;
            r_break_start <= '0;
            r_last_symbol <= '0;
            r_store       <= '0;
            r_count       <= '0;
        end else if (i_step) begin
            r_timing      <= n_timing;
            r_break_start <= n_break_start;
            r_last_symbol <= n_last_symbol;
            r_store       <= n_store;
            r_count       <= n_count;
        end
    end

    assign o_result.matched      = w_match;
    assign o_result.beam_cut     = w_broken;
    assign o_result.symbol_count = 6'(n_count);

    // checks
    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CNT_W'(MAX_SYMBOLS), "store overfull")
    `ASSERT_CLK(a_hold_idle, i_clk, i_rst_n, !i_step |=> $stable(r_count) && $stable(r_store) && $stable(r_timing), "state moved without a step")
    `ASSERT_CLK(a_count_step, i_clk, i_rst_n, i_step |=> (r_count == '0) || (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1), "count jumped by more than one")

endmodule

// File: sv/morse_beam_pattern_detector.sv
// ----------------------------------------------------------------------------
// morse_beam_pattern_detector
// times beam breaks in light samples, decodes dots and dashes and flags a
// match against a programmed target sequence
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ---------------------------------
//  in       sink       i_in_valid / o_in_ready   i_light_sample, i_time_ms
//  out      source     o_out_valid / i_out_ready o_matched, o_beam_cut,
//                                                o_symbol_count
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  one beat per cycle sustained while the output is not stalled; a beat lands
//  in the input register at its accepting edge, the step logic works on it once
//  the result register is free or draining, and its result goes into that register
//  synchronous active-low reset clears the configuration to its defaults and
//  empties the store and the timing phase
//  a stalled output holds the pipe; the input register still takes a beat
//  whenever it is empty or the result register is free or being drained in
//  the same cycle
//
`include "assert_macros.svh"

module morse_beam_pattern_detector
    import mbpd_pkg::*;
#(
    parameter int MAX_SYMBOLS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input beats
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [11:0]            i_light_sample,
    input  logic [31:0]            i_time_ms,
    // result beats
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_matched,
    output logic                   o_beam_cut,
    output logic [5:0]             o_symbol_count,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg        w_cfg;
    t_result     w_result;

    logic        r_in_valid;
    logic [11:0] r_in_sample;
    logic [31:0] r_in_time;
    logic        r_out_valid;
    t_result     r_out;
    logic        w_step;
    logic        w_in_take;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    mbpd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // pipe control: step when the result register is free or draining
    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;
    assign w_in_take  = i_in_valid && o_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_sample <= i_light_sample;
            r_in_time   <= i_time_ms;
        end
    end

    // step logic and state
    mbpd_core #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_sample (r_in_sample),
        .i_time   (r_in_time),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_matched      = r_out.matched;
    assign o_beam_cut     = r_out.beam_cut;
    assign o_symbol_count = r_out.symbol_count;

    // checks
    `ASSERT_CLK(a_match_clears, i_clk, i_rst_n, r_out_valid && r_out.matched |-> r_out.symbol_count == '0, "match left symbols in the store")
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_step |=> r_in_valid && $stable(r_in_time), "pending beat lost")
    `ASSERT_CLK(a_step_result, i_clk, i_rst_n, w_step |=> r_out_valid, "step produced no result")

endmodule

// File: tb/sv/tb_morse_beam_pattern_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_morse_beam_pattern_detector
// self-checking bench for the morse beam pattern detector: sample beats with
// random gaps go in, result beats with random stalls come out, and each one is
// compared with a cycle-free model of the break timer, symbol store and target
// match kept in step at every accepted input beat
// ----------------------------------------------------------------------------
module tb_morse_beam_pattern_detector;
    import mbpd_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int STORE_DEPTH  = 32;
    localparam int RANDOM_ITEMS = 1850;
    localparam int DRAIN_CYCLES = 4;
    localparam int TIMEOUT_NS   = 10_000_000;

    // indexes past the register list, writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    typedef enum int {SYM_NONE, SYM_DOT, SYM_DASH} t_symbol;
    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} t_idle_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [11:0]            i_light_sample;
    logic [31:0]            i_time_ms;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic                   o_matched;
    logic                   o_beam_cut;
    logic [5:0]             o_symbol_count;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // model copy of the registers and the decoder state
    t_cfg        model_cfg;
    logic        break_timing;
    logic [31:0] break_start_ms;
    logic [31:0] last_symbol_ms;
    logic [31:0] stored_symbols;
    int          stored_count;

    t_result     pending_results[$];
    int          error_count = 0;
    int          items_sent  = 0;
    logic [31:0] now_ms;
    t_idle_mode  in_idle  = IDLE_LIGHT;
    t_idle_mode  out_idle = IDLE_LIGHT;

    morse_beam_pattern_detector #(
        .MAX_SYMBOLS(STORE_DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_light_sample (i_light_sample),
        .i_time_ms      (i_time_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_matched      (o_matched),
        .o_beam_cut     (o_beam_cut),
        .o_symbol_count (o_symbol_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #(CLK_HALF);
        i_clk = 1'b1;
        #(CLK_HALF);
    end

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------

    task automatic reset_model();
        model_cfg.light_threshold = RST_THRESHOLD;
        model_cfg.dot_time_ms     = RST_DOT_TIME;
        model_cfg.dash_time_ms    = RST_DASH_TIME;
        model_cfg.idle_timeout_ms = RST_IDLE_TMO;
        model_cfg.target_symbols  = RST_TARGET_SYM;
        model_cfg.target_length   = RST_TARGET_LEN;
        break_timing   = 1'b0;
        break_start_ms = '0;
        last_symbol_ms = '0;
        stored_symbols = '0;
        stored_count   = 0;
    endtask

    // class a break length against the dot and dash windows
    function automatic t_symbol break_class(input logic [31:0] span);
        logic [31:0] dot;
        logic [31:0] dash;
        dot  = {16'h0, model_cfg.dot_time_ms};
        dash = {16'h0, model_cfg.dash_time_ms};
        if (span > MIN_BREAK_MS && span < dot + (dot >> 1))
            return SYM_DOT;
        if (span > dash - (dash >> 1) && span < dash + (dash >> 1))
            return SYM_DASH;
        return SYM_NONE;
    endfunction

    // one sample step, returns the result beat it must produce
    function automatic t_result detector_step(input logic [11:0] sample,
                                              input logic [31:0] t_ms);
        t_result     res;
        t_symbol     sym;
        logic        broken;
        logic        hit;
        logic [31:0] idle_span;
        logic [63:0] mask;
        broken    = sample < model_cfg.light_threshold;
        idle_span = t_ms - last_symbol_ms;
        if (!break_timing) begin
            if (broken) begin
                break_start_ms = t_ms;
                break_timing   = 1'b1;
            end else if (stored_count != 0 && idle_span > model_cfg.idle_timeout_ms) begin
                stored_symbols = '0;
                stored_count   = 0;
            end
        end else if (!broken) begin
            sym = break_class(t_ms - break_start_ms);
            // a full store drops the symbol and keeps the old symbol time
            if (sym != SYM_NONE && stored_count < STORE_DEPTH) begin
                if (sym == SYM_DASH)
                    stored_symbols[stored_count] = 1'b1;
                stored_count++;
                last_symbol_ms = t_ms;
            end
            break_timing = 1'b0;
        end
        // target compare, lengths past the store never match
        hit = 1'b0;
        if (model_cfg.target_length <= TARGET_MAX_LEN &&
            stored_count == model_cfg.target_length) begin
            mask = (64'd1 << model_cfg.target_length) - 64'd1;
            hit  = ((({32'h0, stored_symbols} ^ {32'h0, model_cfg.target_symbols}) & mask)
                    == 64'd0);
        end
        if (hit) begin
            stored_symbols = '0;
            stored_count   = 0;
            break_timing   = 1'b0;
        end
        res.matched      = hit;
        res.beam_cut     = broken;
        res.symbol_count = stored_count[5:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input t_idle_mode mode);
        int r;
        r = $urandom_range(99, 0);
        case (mode)
            IDLE_LIGHT: begin
                if (r < 70) return 0;
                if (r < 95) return $urandom_range(3, 1);
                return $urandom_range(24, 8);
            end
            IDLE_HEAVY: begin
                if (r < 40) return 0;
                if (r < 85) return $urandom_range(4, 1);
                return $urandom_range(30, 10);
            end
            default: return 0;
        endcase
    endfunction

    // one input beat, valid is left high for a back-to-back follower
    task automatic send_sample(input logic [11:0] sample, input logic [31:0] t_ms);
        int gap;
        gap = pick_gap(in_idle);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_light_sample <= sample;
        i_time_ms      <= t_ms;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(detector_step(sample, t_ms));
        items_sent++;
    endtask

    // one register write beat, model follows at acceptance
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        int gap;
        gap = pick_gap(in_idle);
        if (gap > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IDX_THRESHOLD:  model_cfg.light_threshold = data[11:0];
            CFG_IDX_DOT_TIME:   model_cfg.dot_time_ms     = data[15:0];
            CFG_IDX_DASH_TIME:  model_cfg.dash_time_ms    = data[15:0];
            CFG_IDX_IDLE_TMO:   model_cfg.idle_timeout_ms = data;
            CFG_IDX_TARGET_SYM: model_cfg.target_symbols  = data;
            CFG_IDX_TARGET_LEN: model_cfg.target_length   = data[5:0];
            default: ;
        endcase
    endtask

    // park the input and let every result beat drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // full register set, junk in the unused upper data bits
    task automatic program_regs(input t_cfg c);
        logic [31:0] junk;
        wait_idle();
        junk = $urandom();
        if (junk[0])
            write_reg(junk[1] ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO, $urandom());
        write_reg(CFG_IDX_THRESHOLD, {junk[19:0], c.light_threshold});
        write_reg(CFG_IDX_DOT_TIME, {junk[15:0], c.dot_time_ms});
        write_reg(CFG_IDX_DASH_TIME, {junk[31:16], c.dash_time_ms});
        write_reg(CFG_IDX_IDLE_TMO, c.idle_timeout_ms);
        write_reg(CFG_IDX_TARGET_SYM, c.target_symbols);
        write_reg(CFG_IDX_TARGET_LEN, {junk[25:0], c.target_length});
        i_cfg_valid <= 1'b0;
    endtask

    // result ready with random stalls
    initial begin
        int hold;
        hold = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                hold--;
            end else begin
                i_out_ready <= 1'b1;
                hold = pick_gap(out_idle);
            end
        end
    end

    // result check against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no prediction pending");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_matched !== want.matched) begin
                    $error("matched: expected %0d, got %0d", want.matched, o_matched);
                    error_count++;
                end
                if (o_beam_cut !== want.beam_cut) begin
                    $error("beam_cut: expected %0d, got %0d",
                           want.beam_cut, o_beam_cut);
                    error_count++;
                end
                if (o_symbol_count !== want.symbol_count) begin
                    $error("symbol_count: expected %0d, got %0d",
                           want.symbol_count, o_symbol_count);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [11:0] pick_broken();
        if (model_cfg.light_threshold == 0)
            return 12'($urandom_range(4095, 0));
        return 12'($urandom_range(int'(model_cfg.light_threshold) - 1, 0));
    endfunction

    function automatic logic [11:0] pick_intact();
        return 12'($urandom_range(4095, int'(model_cfg.light_threshold)));
    endfunction

    function automatic int pick_extra();
        return ($urandom_range(3, 0) == 0) ? $urandom_range(2, 1) : 0;
    endfunction

    // one break of the given length, optional extra broken beats inside it
    task automatic send_pulse(input logic [31:0] span, input int extra);
        logic [31:0] t0;
        int          k;
        t0 = now_ms;
        send_sample(pick_broken(), t0);
        for (k = 1; k <= extra; k++)
            send_sample(pick_broken(), t0 + span / (extra + 1) * k);
        now_ms = t0 + span;
        send_sample(pick_intact(), now_ms);
    endtask

    task automatic send_idle(input logic [31:0] span);
        now_ms = now_ms + span;
        send_sample(pick_intact(), now_ms);
    endtask

    // break length inside the dot or the dash window, edges favored
    function automatic logic [31:0] symbol_span(input bit dash_sym);
        int dot;
        int dash;
        int lo;
        int hi;
        dot  = model_cfg.dot_time_ms;
        dash = model_cfg.dash_time_ms;
        if (dash_sym) begin
            lo = dash - dash / 2 + 1;
            if (lo < dot + dot / 2)
                lo = dot + dot / 2;
            hi = dash + dash / 2 - 1;
        end else begin
            lo = int'(MIN_BREAK_MS) + 1;
            hi = dot + dot / 2 - 1;
        end
        case ($urandom_range(7, 0))
            0: return 32'(lo);
            1: return 32'(hi);
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // break length that should class as nothing
    function automatic logic [31:0] bad_span();
        int dash;
        dash = model_cfg.dash_time_ms;
        case ($urandom_range(3, 0))
            0: return MIN_BREAK_MS;
            1: return $urandom_range(int'(MIN_BREAK_MS) - 1, 0);
            2: return 32'(dash + dash / 2);
            default: return 32'(dash + dash / 2) + $urandom_range(500, 1);
        endcase
    endfunction

    function automatic logic [31:0] pick_field(input logic [31:0] top);
        case ($urandom_range(2, 0))
            0: return '0;
            1: return top;
            default: return $urandom_range(top, 0);
        endcase
    endfunction

    // decodable timing: dash time clear of the dot window
    function automatic t_cfg word_cfg(input bit fill);
        t_cfg c;
        int   dot;
        int   dash;
        case ($urandom_range(3, 0))
            0: c.light_threshold = 12'd1;
            1: c.light_threshold = 12'd4095;
            default: c.light_threshold = 12'($urandom_range(4095, 1));
        endcase
        if ($urandom_range(9, 0) == 0) begin
            dot  = 43690;
            dash = 65535;
        end else begin
            dot  = ($urandom_range(5, 0) == 0) ? 35 : $urandom_range(1500, 35);
            dash = 2 * dot + $urandom_range(dot, 0);
        end
        c.dot_time_ms    = 16'(dot);
        c.dash_time_ms   = 16'(dash);
        c.target_symbols = $urandom();
        if (fill) begin
            c.idle_timeout_ms = '1;
            c.target_length   = 6'($urandom_range(63, int'(TARGET_MAX_LEN) + 1));
        end else begin
            c.idle_timeout_ms = 32'(dash + dash / 2 + 1000) + $urandom_range(5000, 0);
            case ($urandom_range(7, 0))
                0: c.target_length = '0;
                1: c.target_length = TARGET_MAX_LEN;
                default: c.target_length = 6'($urandom_range(6, 1));
            endcase
        end
        return c;
    endfunction

    // any register values, extremes favored
    function automatic t_cfg noise_cfg();
        t_cfg c;
        c.light_threshold = 12'(pick_field(32'hFFF));
        c.dot_time_ms     = 16'(pick_field(32'hFFFF));
        c.dash_time_ms    = 16'(pick_field(32'hFFFF));
        c.idle_timeout_ms = pick_field(32'hFFFF_FFFF);
        c.target_symbols  = pick_field(32'hFFFF_FFFF);
        case ($urandom_range(5, 0))
            0: c.target_length = '0;
            1: c.target_length = TARGET_MAX_LEN;
            2: c.target_length = TARGET_MAX_LEN + 6'd1;
            3: c.target_length = '1;
            default: c.target_length = 6'($urandom_range(63, 0));
        endcase
        return c;
    endfunction

    // target words with random timing, some corrupted, plus timeout steps
    task automatic run_words(input bit fill);
        int start;
        int quota;
        int count;
        int i;
        bit sym;
        start = items_sent;
        quota = $urandom_range(160, 100);
        // close any open break, flush the store unless the timeout is all ones
        send_idle(1);
        if (model_cfg.idle_timeout_ms != '1)
            send_idle(model_cfg.idle_timeout_ms + 1);
        while (items_sent - start < quota) begin
            if (fill)
                count = $urandom_range(40, 34);
            else if (model_cfg.target_length == 0)
                count = $urandom_range(4, 1);
            else
                count = model_cfg.target_length;
            for (i = 0; i < count; i++) begin
                if (fill || model_cfg.target_length == 0)
                    sym = 1'($urandom_range(1, 0));
                else
                    sym = model_cfg.target_symbols[i];
                case ($urandom_range(23, 0))
                    0: send_pulse(bad_span(), 0);
                    1: send_pulse(symbol_span(!sym), pick_extra());
                    default: send_pulse(symbol_span(sym), pick_extra());
                endcase
                if ($urandom_range(2, 0) == 0)
                    send_idle($urandom_range(200, 1));
            end
            // gap after the word, on and around the idle timeout
            case ($urandom_range(9, 0))
                0, 1, 2: begin
                    if (!fill)
                        send_idle(model_cfg.idle_timeout_ms + 1);
                end
                3: begin
                    if (!fill) begin
                        send_idle(model_cfg.idle_timeout_ms);
                        send_idle(1);
                    end
                end
                default: send_idle($urandom_range(300, 1));
            endcase
        end
    endtask

    // random breaks and raw samples, time jumping anywhere
    task automatic run_noise();
        int          start;
        int          quota;
        int          dash;
        logic [31:0] span;
        start = items_sent;
        quota = $urandom_range(160, 100);
        dash  = model_cfg.dash_time_ms;
        while (items_sent - start < quota) begin
            if ($urandom_range(9, 0) < 5) begin
                span = $urandom_range(1, 0) ? $urandom_range(2 * dash + 200, 0) : $urandom();
                send_pulse(span, $urandom_range(1, 0));
            end else begin
                now_ms = $urandom_range(1, 0) ? now_ms + $urandom_range(3000, 0) : $urandom();
                send_sample(12'($urandom_range(4095, 0)), now_ms);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset registers: empty target, sample extremes, timeout edge
    task automatic test_reset_defaults();
        send_sample(12'h000, 32'h0000_0000);
        send_sample(12'hFFF, 32'hFFFF_FFFF);
        send_sample(RST_THRESHOLD - 12'd1, 32'd100);
        send_sample(RST_THRESHOLD, 32'd200);
        send_sample(12'hFFF, 32'd200 + RST_IDLE_TMO);
        send_sample(RST_THRESHOLD, 32'd201 + RST_IDLE_TMO);
        now_ms = 32'd201 + RST_IDLE_TMO;
    endtask

    // window edges of dot and dash, break across the time wrap
    task automatic test_break_bounds();
        t_cfg c;
        int   spans [7] = '{50, 51, 299, 300, 301, 899, 900};
        int   i;
        c.light_threshold = RST_THRESHOLD;
        c.dot_time_ms     = RST_DOT_TIME;
        c.dash_time_ms    = RST_DASH_TIME;
        c.idle_timeout_ms = '1;
        c.target_symbols  = '0;
        c.target_length   = TARGET_MAX_LEN + 6'd1;
        program_regs(c);
        now_ms = 32'd1000;
        for (i = 0; i < 7; i++)
            send_pulse(32'(spans[i]), 0);
        now_ms = 32'hFFFF_FFC0;
        send_pulse(32'd112, 0);
    endtask

    // dash-dot target, wrong word, idle timeout on both sides of the edge
    task automatic test_match_and_timeout();
        t_cfg c;
        c.light_threshold = RST_THRESHOLD;
        c.dot_time_ms     = RST_DOT_TIME;
        c.dash_time_ms    = RST_DASH_TIME;
        c.idle_timeout_ms = 32'd100;
        c.target_symbols  = 32'h0000_0001;
        c.target_length   = 6'd2;
        program_regs(c);
        now_ms = 32'd5000;
        send_pulse(32'd600, 0);
        send_pulse(32'd150, 0);
        send_pulse(32'd150, 0);
        send_idle(32'd100);
        send_idle(32'd1);
        send_pulse(32'd600, 0);
        send_pulse(32'd600, 0);
        send_idle(32'd101);
    endtask

    // phases of random registers and traffic, idling changed per phase
    task automatic test_random_traffic();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            in_idle  = t_idle_mode'($urandom_range(2, 0));
            out_idle = t_idle_mode'($urandom_range(2, 0));
            if ($urandom_range(5, 0) == 0)
                now_ms = 32'hFFFF_FFFF - $urandom_range(3000, 0);
            case ($urandom_range(9, 0))
                0, 1, 2, 3, 4, 5: begin
                    program_regs(word_cfg(1'b0));
                    run_words(1'b0);
                end
                6, 7: begin
                    program_regs(noise_cfg());
                    run_noise();
                end
                default: begin
                    program_regs(word_cfg(1'b1));
                    run_words(1'b1);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_light_sample <= '0;
        i_time_ms      <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        now_ms = '0;
        reset_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_break_bounds();
        test_match_and_timeout();
        test_random_traffic();
        wait_idle();

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/mbpd_pkg.sv
sv/mbpd_cfg.sv
sv/mbpd_core.sv
sv/morse_beam_pattern_detector.sv
tb/sv/tb_morse_beam_pattern_detector.sv
